// ===== hdl/vcp_pkg.sv =====
// shared constants, codes and types of the vcpu core packer
`timescale 1ns / 1ps

package vcp_pkg;

    // table and pass sizes
    localparam int NUM_SLOTS = 64;
    localparam int MAX_VMS   = 256;

    // derived widths
    localparam int CORE_AW = $clog2(NUM_SLOTS);
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
    localparam int VM_W    = $clog2(MAX_VMS + 1);
    localparam int THR_W   = 4;
    localparam int CEIL_W  = 10;

    // request kinds carried in tuser
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_BEGIN   = 2'd1;
    localparam logic [1:0] MODE_REQUEST = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CORE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_VCPU_CEILING = 2'd1;

    // divider start and operands
    typedef struct packed {
        logic              go;
        logic [CEIL_W-1:0] dividend;
        logic [THR_W-1:0]  divisor;
    } div_req_t;

    // divider completion and quotient
    typedef struct packed {
        logic              done;
        logic [CEIL_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hdl/vcp_ram.sv =====
// simple dual-port synchronous ram with registered read data
`timescale 1ns / 1ps

module vcp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 4
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/vcp_div.sv =====
// restoring divider for ceiling over fewest threads, one quotient bit a cycle
`timescale 1ns / 1ps

module vcp_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  vcp_pkg::div_req_t req,
    output vcp_pkg::div_rsp_t rsp
);

    localparam int STEP_W = $clog2(vcp_pkg::CEIL_W + 1);

    logic [vcp_pkg::THR_W-1:0]  rem_reg;
    logic [vcp_pkg::CEIL_W-1:0] quo_reg;
    logic [vcp_pkg::THR_W-1:0]  dvs_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [vcp_pkg::THR_W:0]    shifted;
    logic                       fits;

    // trial subtraction
    assign shifted = {rem_reg, quo_reg[vcp_pkg::CEIL_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.go) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(vcp_pkg::CEIL_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.go) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= vcp_pkg::THR_W'(shifted - {1'b0, dvs_reg});
            end else begin
                rem_reg <= shifted[vcp_pkg::THR_W-1:0];
            end
            quo_reg <= {quo_reg[vcp_pkg::CEIL_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/vcpu_core_packer.sv =====
// top level: core table, scan sequencer, ceiling cap and result register
//
//  channel  | direction | handshake            | content
//  s_axis   | in        | tvalid / tready      | load, begin pass or vm request
//  m_axis   | out       | tvalid / tready      | one result per vm request, at most 256 a pass
//  cfg      | in        | cfg_valid / cfg_ready| core_count, vcpu_ceiling writes
//
// A vm request walks the core table in the scan step, waits for the serial divider
// when the ceiling is nonzero, and ends in the emit step. The walk reads the core
// table one entry per cycle through its single read port. Reset clears the cursor,
// counters and output valid flag; the table itself is not cleared. A stalled result
// output holds the block in its final step, while an earlier result waits in the
// output register.
`timescale 1ns / 1ps

module vcpu_core_packer (
    input  logic        aclk,
    input  logic        aresetn,
    // cfg
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // core_index[5:0], thread_count[9:6],
                                       // cores_wanted[16:10], zero pad
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // vm_index[7:0], base_core[14:8],
                                       // cores_given[21:15],
                                       // min_threads[25:22],
                                       // vcpu_total[35:26], shortfall[36],
                                       // launchable_prefix[45:37], zero pad
);

    localparam int CNT_W  = vcp_pkg::CNT_W;
    localparam int VM_W   = vcp_pkg::VM_W;
    localparam int THR_W  = vcp_pkg::THR_W;
    localparam int CEIL_W = vcp_pkg::CEIL_W;
    localparam int AW     = vcp_pkg::CORE_AW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [CNT_W-1:0]  core_count_reg;
    logic [CEIL_W-1:0] vcpu_ceiling_reg;

    // pass state
    logic [CNT_W-1:0]  core_cursor_reg;
    logic [VM_W-1:0]   vm_counter_reg;
    logic              miss_seen_reg;
    logic [VM_W-1:0]   first_miss_reg;

    // per request work registers
    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  want_reg;
    logic [CNT_W-1:0]  taken_reg;
    logic [CNT_W-1:0]  start_reg;
    logic [THR_W-1:0]  fewest_reg;
    logic              div_go_reg;

    // result register
    logic              m_valid_reg;
    logic [47:0]       m_data_reg;

    // input fields
    logic [1:0]        in_mode;
    logic [AW-1:0]     in_core_index;
    logic [THR_W-1:0]  in_thread_count;
    logic [CNT_W-1:0]  in_cores_wanted;
    logic              in_fire;

    // table access
    logic              ram_wr_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [THR_W-1:0]  ram_rd_data;
    logic [CNT_W-1:0]  cursor_inc;

    // scan and finish logic
    logic              take;
    logic [CEIL_W-1:0] cap;
    logic              out_free;
    logic              short_vm;
    logic              miss_next;
    logic [VM_W-1:0]   first_miss_next;
    logic [VM_W-1:0]   vm_counter_next;
    logic [CEIL_W-1:0] product;

    vcp_pkg::div_req_t div_req;
    vcp_pkg::div_rsp_t div_rsp;

    assign in_mode         = s_axis_tuser;
    assign in_core_index   = s_axis_tdata[5:0];
    assign in_thread_count = s_axis_tdata[9:6];
    assign in_cores_wanted = s_axis_tdata[16:10];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // core table
    assign ram_wr_en   = in_fire && (in_mode == vcp_pkg::MODE_LOAD);
    assign cursor_inc  = core_cursor_reg + 1'b1;
    assign ram_rd_addr = (state_reg == ST_SCAN) ? cursor_inc[AW-1:0]
                                                : core_cursor_reg[AW-1:0];

    vcp_ram #(
        .DEPTH(vcp_pkg::NUM_SLOTS),
        .WIDTH(THR_W)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(in_core_index),
        .wr_data(in_thread_count),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    // ceiling divider
    assign div_req.go       = div_go_reg;
    assign div_req.dividend = vcp_pkg::CEIL_W'(vcpu_ceiling_reg);
    assign div_req.divisor  = fewest_reg;

    vcp_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // walk step: the read data belongs to the current cursor
    assign take = (taken_reg < want_reg) && (core_cursor_reg < limit_reg)
                  && (ram_rd_data != '0);

    // cap of at least one core
    assign cap = (div_rsp.quotient == '0) ? CEIL_W'(1) : div_rsp.quotient;

    // finish values
    assign out_free        = !m_valid_reg || m_axis_tready;
    assign short_vm        = taken_reg < want_reg;
    assign miss_next       = miss_seen_reg || short_vm;
    assign first_miss_next = miss_seen_reg ? first_miss_reg : vm_counter_reg;
    assign vm_counter_next = vm_counter_reg + 1'b1;
    assign product         = CEIL_W'(taken_reg) * CEIL_W'(fewest_reg);

    // sequencer, pass state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            core_count_reg   <= '0;
            vcpu_ceiling_reg <= '0;
            core_cursor_reg  <= '0;
            vm_counter_reg   <= '0;
            miss_seen_reg    <= 1'b0;
            first_miss_reg   <= '0;
            div_go_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            div_go_reg <= 1'b0;
            if (m_valid_reg && m_axis_tready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            // register writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    vcp_pkg::CFG_CORE_COUNT:   core_count_reg   <= cfg_data[CNT_W-1:0];
                    vcp_pkg::CFG_VCPU_CEILING: vcpu_ceiling_reg <= cfg_data;
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        unique case (in_mode)
                            vcp_pkg::MODE_BEGIN: begin
                                core_cursor_reg <= '0;
                                vm_counter_reg  <= '0;
                                miss_seen_reg   <= 1'b0;
                                first_miss_reg  <= '0;
                            end
                            vcp_pkg::MODE_REQUEST: begin
                                if (vm_counter_reg < VM_W'(vcp_pkg::MAX_VMS)) begin
                                    want_reg   <= (in_cores_wanted == '0) ? CNT_W'(1)
                                                                          : in_cores_wanted;
                                    limit_reg  <= (core_count_reg > CNT_W'(vcp_pkg::NUM_SLOTS))
                                                  ? CNT_W'(vcp_pkg::NUM_SLOTS)
                                                  : core_count_reg;
                                    start_reg  <= core_cursor_reg;
                                    taken_reg  <= '0;
                                    fewest_reg <= '0;
                                    state_reg  <= ST_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (take) begin
                        taken_reg       <= taken_reg + 1'b1;
                        core_cursor_reg <= cursor_inc;
                        if (fewest_reg == '0 || ram_rd_data < fewest_reg) begin
                            fewest_reg <= ram_rd_data;
                        end
                    end else begin
                        if (fewest_reg == '0) begin
                            fewest_reg <= THR_W'(1);
                        end
                        if (vcpu_ceiling_reg != '0) begin
                            div_go_reg <= 1'b1;
                            state_reg  <= ST_DIV;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        // hand extra cores back and lower the want
                        if ({{(CEIL_W-CNT_W){1'b0}}, taken_reg} > cap) begin
                            core_cursor_reg <= core_cursor_reg - taken_reg
                                               + cap[CNT_W-1:0];
                            taken_reg       <= cap[CNT_W-1:0];
                        end
                        if ({{(CEIL_W-CNT_W){1'b0}}, want_reg} > cap) begin
                            want_reg <= cap[CNT_W-1:0];
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_data_reg     <= {2'b00,
                                           miss_next ? first_miss_next : vm_counter_next,
                                           short_vm,
                                           product,
                                           fewest_reg,
                                           taken_reg,
                                           start_reg,
                                           vm_counter_reg[7:0]};
                        miss_seen_reg  <= miss_next;
                        first_miss_reg <= short_vm ? first_miss_next : first_miss_reg;
                        vm_counter_reg <= vm_counter_next;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    // the cursor never runs past the table
    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        core_cursor_reg <= CNT_W'(vcp_pkg::NUM_SLOTS))
        else $error("core cursor beyond table");

    // a walk never takes more cores than wanted
    a_taken_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (taken_reg <= want_reg))
        else $error("walk took more cores than wanted");

    // divider completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider done outside of divide step");

    // a new result is only loaded from the final step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_EMIT))
        else $error("result loaded outside of final step");
`endif

endmodule
